/* rtl/core/stpq_pkg.sv */
// Shared types and codes for the sequenced trajectory point queue.
// Holds command, mode, status and sequencer enums plus the beat and entry structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stpq_pkg;

  typedef enum logic [1:0] {
    CMD_RESET_PUSH    = 2'd0,
    CMD_PUSH          = 2'd1,
    CMD_TAKE          = 2'd2,
    CMD_REQUIRE_RESET = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PREFILL = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_RESET_NEEDED = 3'd1,
    ST_SEQ_ERROR    = 3'd2,
    ST_FULL         = 3'd3,
    ST_HOLD         = 3'd4,
    ST_WAIT         = 3'd5,
    ST_GRACE        = 3'd6,
    ST_POINT        = 3'd7
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  // Fault codes latched as hold reasons
  localparam logic [7:0] ReasonSequence = 8'd1;
  localparam logic [7:0] ReasonOverflow = 8'd2;
  localparam logic [7:0] ReasonUnderrun = 8'd3;
  localparam logic [7:0] ReasonExpired  = 8'd4;

  // Register indexes on the configuration port
  localparam logic RegPrefillThreshold = 1'b0;
  localparam logic RegGraceLimit       = 1'b1;

  localparam logic [4:0] PrefillThresholdReset = 5'd4;
  localparam logic [7:0] GraceLimitReset       = 8'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  point_sequence;
    logic [31:0] point_tick;
    logic [15:0] point_validity;
    logic [63:0] point_payload;
    logic [31:0] now_tick;
    logic [7:0]  hold_reason_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_sequence;
    logic [31:0] out_tick;
    logic [15:0] out_validity;
    logic [63:0] out_payload;
    logic [31:0] out_generation;
    logic [1:0]  run_state;
    logic        rebuild_needed;
    logic [4:0]  point_count;
    logic [7:0]  hold_reason_out;
    logic [7:0]  next_sequence;
  } out_item_t;

  // One queued point as it sits in the ring storage
  typedef struct packed {
    logic [7:0]  seq;
    logic [31:0] tick;
    logic [15:0] validity;
    logic [63:0] payload;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/sequenced_trajectory_point_queue.sv */
// Top level of the sequenced trajectory point queue.
// Instantiates stpq_store and stpq_ctrl; holds the APB registers, sequencer and
// output register. Uses stpq_pkg.
//
// Usage:
//   - Command beats enter on in_item_i with in_valid_i/in_ready_o. Each beat
//     carries one of reset_push, push, take or require_reset and yields exactly
//     one result beat on out_item_o with out_valid_o/out_ready_i.
//   - Each accepted beat is handled in order: the head entry is read from the
//     ring memory (registered read port), then the command is resolved and
//     committed. A new beat is accepted only after the previous one commits;
//     the result is loaded into the output register at commit.
//   - The output register decouples the sides: a new command beat is accepted
//     while the previous result still waits. When the receiver stalls with a
//     result pending, the next command is held in the resolve cycle and commits
//     as soon as the output register frees.
//   - Reset leaves the queue idle with a rebuild required; the ring memories
//     are not cleared, since no entry is read before it is written. Registers
//     return to prefill_threshold 4 and grace_limit 2.
//   - Configuration: APB at paddr 0 (prefill_threshold) and 4 (grace_limit);
//     write only while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module sequenced_trajectory_point_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire stpq_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output stpq_pkg::out_item_t      out_item_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);

  stpq_pkg::fsm_e      fsm_q, fsm_d;
  stpq_pkg::in_item_t  item_q;
  stpq_pkg::out_item_t out_q;
  stpq_pkg::out_item_t result;
  stpq_pkg::entry_t    head_entry;
  stpq_pkg::entry_t    wr_entry;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                commit;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [IdxW-1:0]     head_addr;
  logic [4:0]          prefill_threshold_q;
  logic [7:0]          grace_limit_q;
  logic                cfg_write;

  // APB: zero-wait, register select on paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefill_threshold_q <= stpq_pkg::PrefillThresholdReset;
      grace_limit_q       <= stpq_pkg::GraceLimitReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        stpq_pkg::RegPrefillThreshold: prefill_threshold_q <= pwdata[4:0];
        stpq_pkg::RegGraceLimit:       grace_limit_q       <= pwdata[7:0];
        default:                       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      stpq_pkg::RegPrefillThreshold: prdata = {27'd0, prefill_threshold_q};
      stpq_pkg::RegGraceLimit:       prdata = {24'd0, grace_limit_q};
      default:                       prdata = '0;
    endcase
  end

  // Sequencer: idle accepts a beat, exec resolves it once the output register is free
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (fsm_q == stpq_pkg::FSM_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (fsm_q == stpq_pkg::FSM_IDLE);

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      stpq_pkg::FSM_IDLE: begin
        if (accept) begin
          fsm_d = stpq_pkg::FSM_EXEC;
        end
      end
      stpq_pkg::FSM_EXEC: begin
        if (commit) begin
          fsm_d = stpq_pkg::FSM_IDLE;
        end
      end
      default: fsm_d = stpq_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= stpq_pkg::FSM_IDLE;
    end else begin
      fsm_q <= fsm_d;
    end
  end

  // Hold the accepted command for the resolve cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // Output register: load on commit, drop when the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  stpq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en && commit),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_addr_i  (head_addr),
    .rd_entry_o (head_entry)
  );

  stpq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .commit_i            (commit),
    .item_i              (item_q),
    .prefill_threshold_i (prefill_threshold_q),
    .grace_limit_i       (grace_limit_q),
    .head_entry_i        (head_entry),
    .head_addr_o         (head_addr),
    .wr_en_o             (wr_en),
    .wr_addr_o           (wr_addr),
    .wr_entry_o          (wr_entry),
    .result_o            (result)
  );

endmodule

`default_nettype wire

/* rtl/core/stpq_store.sv */
// Ring storage for queued points: metadata and payload memories.
// One write port, one registered read port. Uses stpq_pkg::entry_t.
`timescale 1ns / 1ps
`default_nettype none

module stpq_store #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr_i,
  input  wire stpq_pkg::entry_t               wr_entry_i,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr_i,
  output stpq_pkg::entry_t                    rd_entry_o
);

  logic [55:0] meta_mem [QUEUE_DEPTH];
  logic [63:0] payload_mem [QUEUE_DEPTH];
  logic [55:0] meta_rd_q;
  logic [63:0] payload_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      meta_mem[wr_addr_i]    <= {wr_entry_i.seq, wr_entry_i.tick, wr_entry_i.validity};
      payload_mem[wr_addr_i] <= wr_entry_i.payload;
    end
  end

  always_ff @(posedge clk_i) begin
    meta_rd_q    <= meta_mem[rd_addr_i];
    payload_rd_q <= payload_mem[rd_addr_i];
  end

  assign rd_entry_o.seq      = meta_rd_q[55:48];
  assign rd_entry_o.tick     = meta_rd_q[47:16];
  assign rd_entry_o.validity = meta_rd_q[15:0];
  assign rd_entry_o.payload  = payload_rd_q;

endmodule

`default_nettype wire

/* rtl/core/stpq_ctrl.sv */
// Queue control: mode, pointers, count, sequence check, grace and hold reason.
// Resolves one command against the head entry read from stpq_store. Uses stpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stpq_ctrl #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           commit_i,
  input  wire stpq_pkg::in_item_t             item_i,
  input  wire logic [4:0]                     prefill_threshold_i,
  input  wire logic [7:0]                     grace_limit_i,
  input  wire stpq_pkg::entry_t               head_entry_i,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      head_addr_o,
  output logic                                wr_en_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr_o,
  output stpq_pkg::entry_t                    wr_entry_o,
  output stpq_pkg::out_item_t                 result_o
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int CmpW = (CntW > 5) ? CntW : 5;

  stpq_pkg::mode_e mode_q, mode_d;
  logic            rebuild_q, rebuild_d;
  logic            expv_q, expv_d;
  logic [7:0]      exp_seq_q, exp_seq_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      grace_q, grace_d;
  logic [7:0]      reason_q, reason_d;
  logic [31:0]     gen_q, gen_d;

  logic [31:0]     age;
  logic            expired;
  logic            queue_full;
  logic            queue_empty;
  logic            prefill_done;
  logic [IdxW-1:0] tail_inc;
  logic [IdxW-1:0] head_inc;
  logic [7:0]      fault_reason;
  logic            fault;
  stpq_pkg::status_e status;
  logic            pop;

  assign age          = item_i.now_tick - head_entry_i.tick;
  assign expired      = (age >= {16'd0, head_entry_i.validity});
  assign queue_full   = (count_q == CntW'(QUEUE_DEPTH));
  assign queue_empty  = (count_q == '0);
  assign prefill_done = (CmpW'(count_q) >= CmpW'(prefill_threshold_i));
  assign tail_inc     = (tail_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign head_inc     = (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  assign head_addr_o = head_q;
  assign wr_entry_o  = '{seq:      item_i.point_sequence,
                         tick:     item_i.point_tick,
                         validity: item_i.point_validity,
                         payload:  item_i.point_payload};

  always_comb begin
    mode_d       = mode_q;
    rebuild_d    = rebuild_q;
    expv_d       = expv_q;
    exp_seq_d    = exp_seq_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    grace_d      = grace_q;
    reason_d     = reason_q;
    gen_d        = gen_q;
    fault        = 1'b0;
    fault_reason = '0;
    status       = stpq_pkg::ST_OK;
    pop          = 1'b0;
    wr_en_o      = 1'b0;
    wr_addr_o    = tail_q;

    unique case (item_i.command)
      stpq_pkg::CMD_RESET_PUSH: begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        head_d    = '0;
        tail_d    = IdxW'(1);
        count_d   = CntW'(1);
        grace_d   = '0;
        exp_seq_d = item_i.point_sequence + 8'd1;
        expv_d    = 1'b1;
        rebuild_d = 1'b0;
        gen_d     = gen_q + 32'd1;
        reason_d  = '0;
        mode_d    = stpq_pkg::MODE_PREFILL;
      end
      stpq_pkg::CMD_PUSH: begin
        priority if (rebuild_q || !expv_q ||
                     (mode_q != stpq_pkg::MODE_PREFILL &&
                      mode_q != stpq_pkg::MODE_RUNNING)) begin
          status = stpq_pkg::ST_RESET_NEEDED;
        end else if (item_i.point_sequence != exp_seq_q) begin
          fault        = 1'b1;
          fault_reason = stpq_pkg::ReasonSequence;
          status       = stpq_pkg::ST_SEQ_ERROR;
        end else if (queue_full) begin
          fault        = 1'b1;
          fault_reason = stpq_pkg::ReasonOverflow;
          status       = stpq_pkg::ST_FULL;
        end else begin
          if (mode_q == stpq_pkg::MODE_RUNNING && queue_empty) begin
            grace_d = '0;
          end
          wr_en_o   = 1'b1;
          tail_d    = tail_inc;
          count_d   = count_q + 1'b1;
          exp_seq_d = item_i.point_sequence + 8'd1;
        end
      end
      stpq_pkg::CMD_TAKE: begin
        if (rebuild_q || mode_q == stpq_pkg::MODE_HOLD) begin
          status = stpq_pkg::ST_HOLD;
        end else begin
          if (mode_q == stpq_pkg::MODE_PREFILL && prefill_done) begin
            mode_d  = stpq_pkg::MODE_RUNNING;
            grace_d = '0;
          end
          priority if (mode_d != stpq_pkg::MODE_RUNNING) begin
            status = stpq_pkg::ST_WAIT;
          end else if (queue_empty) begin
            if (grace_d < grace_limit_i) begin
              grace_d = grace_d + 8'd1;
              status  = stpq_pkg::ST_GRACE;
            end else begin
              fault        = 1'b1;
              fault_reason = stpq_pkg::ReasonUnderrun;
              status       = stpq_pkg::ST_HOLD;
            end
          end else if (expired) begin
            fault        = 1'b1;
            fault_reason = stpq_pkg::ReasonExpired;
            status       = stpq_pkg::ST_HOLD;
          end else begin
            grace_d = '0;
            pop     = 1'b1;
            head_d  = head_inc;
            count_d = count_q - 1'b1;
            status  = stpq_pkg::ST_POINT;
          end
        end
      end
      stpq_pkg::CMD_REQUIRE_RESET: begin
        fault        = 1'b1;
        fault_reason = item_i.hold_reason_in;
        status       = stpq_pkg::ST_HOLD;
      end
      default: begin
        status = stpq_pkg::ST_HOLD;
      end
    endcase

    // Flush the ring and park in hold; keep the first nonzero reason
    if (fault) begin
      if (reason_q == '0 && fault_reason != '0) begin
        reason_d = fault_reason;
      end
      mode_d    = stpq_pkg::MODE_HOLD;
      rebuild_d = 1'b1;
      expv_d    = 1'b0;
      exp_seq_d = '0;
      head_d    = '0;
      tail_d    = '0;
      count_d   = '0;
      grace_d   = '0;
    end
  end

  always_comb begin
    result_o                 = '0;
    result_o.status          = status;
    result_o.run_state       = mode_d;
    result_o.rebuild_needed  = rebuild_d;
    result_o.point_count     = 5'(count_d);
    result_o.hold_reason_out = reason_d;
    result_o.next_sequence   = exp_seq_d;
    if (pop) begin
      result_o.out_sequence   = head_entry_i.seq;
      result_o.out_tick       = head_entry_i.tick;
      result_o.out_validity   = head_entry_i.validity;
      result_o.out_payload    = head_entry_i.payload;
      result_o.out_generation = gen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stpq_pkg::MODE_IDLE;
      rebuild_q <= 1'b1;
      expv_q    <= 1'b0;
      exp_seq_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      grace_q   <= '0;
      reason_q  <= '0;
      gen_q     <= '0;
    end else if (commit_i) begin
      mode_q    <= mode_d;
      rebuild_q <= rebuild_d;
      expv_q    <= expv_d;
      exp_seq_q <= exp_seq_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      grace_q   <= grace_d;
      reason_q  <= reason_d;
      gen_q     <= gen_d;
    end
  end

endmodule

`default_nettype wire
